// ===== sv/ped_pkg.sv =====
// Package for the percent escape decoder: request and result structs,
// escape phase enum, decoder state struct and status codes. No dependencies.
package ped_pkg;

  // Widths of the request, result and decoder state fields
  localparam int unsigned CharW   = 21;
  localparam int unsigned AccumW  = 16;
  localparam int unsigned DigitW  = 3;
  localparam int unsigned SurrW   = 10;
  localparam int unsigned StatusW = 2;

  // Result status codes
  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_TRUNCATED = 2'd1;
  localparam logic [StatusW-1:0] STAT_ILLEGAL   = 2'd2;
  localparam logic [StatusW-1:0] STAT_UNPAIRED  = 2'd3;

  // Character codes and constants used by the decoder
  localparam logic [CharW-1:0] CHR_PERCENT = 21'h25;
  localparam logic [CharW-1:0] CHR_LOW_U   = 21'h75;
  localparam logic [CharW-1:0] CHR_UP_U    = 21'h55;
  localparam logic [CharW-1:0] CHR_ZERO    = 21'h30;
  localparam logic [CharW-1:0] CHR_NINE    = 21'h39;
  localparam logic [CharW-1:0] CHR_LOW_A   = 21'h61;
  localparam logic [CharW-1:0] CHR_LOW_F   = 21'h66;
  localparam logic [CharW-1:0] CHR_UP_A    = 21'h41;
  localparam logic [CharW-1:0] CHR_UP_F    = 21'h46;
  localparam logic [CharW-1:0] SUPP_BASE   = 21'h10000;
  localparam logic [4:0]       SURR_TAG    = 5'b11011;  // top bits of 0xd800..0xdfff
  localparam logic [DigitW-1:0] UNIT_DIGITS = 3'd4;
  localparam logic [DigitW-1:0] BYTE_DIGITS = 3'd1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PCT  = 3'd1,
    PH_BYTE = 3'd2,
    PH_UNIT = 3'd3,
    PH_BAD  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0]   code_point;
    logic               final_res;
    logic [StatusW-1:0] status;
  } out_item_t;

  typedef struct packed {
    phase_e              escape_phase;
    logic [AccumW-1:0]   hex_accum;
    logic [DigitW-1:0]   digits_left;
    logic [SurrW-1:0]    high_surrogate;
    logic                high_pending;
    logic                error_latched;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    escape_phase:   PH_IDLE,
    hex_accum:      '0,
    digits_left:    '0,
    high_surrogate: '0,
    high_pending:   1'b0,
    error_latched:  1'b0
  };

endpackage

// ===== sv/percent_escape_decoder_top.sv =====
// Top level of the percent escape decoder: decoder core and result buffer.
// Depends on ped_pkg, ped_core and ped_outbuf.
//
// Takes one character per cycle while in_stall_o is low and gives at most
// one registered result per character. Plain characters pass through, %XX
// and %uXXXX/%UXXXX escapes are decoded, and a high/low surrogate pair from
// unit escapes is merged into one code point. An error gives one result with
// final_res set and drops the rest of the string. The parser state update is
// a single register stage, so a request is taken every cycle that in_stall_o
// is low; a two-entry result buffer (output register plus skid entry) raises
// in_stall_o only when both entries hold results the receiver has not taken.
module percent_escape_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ped_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ped_pkg::out_item_t out_item_o
);

  logic               accept;
  logic               res_valid;
  ped_pkg::out_item_t res_item;
  logic               full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Parse the incoming character
  ped_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  // Hold results for the receiver
  ped_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_item_i (res_item),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sv/ped_core.sv =====
// Decoder core: state registers and the per-character next-state and
// result logic. Depends on ped_pkg.
module ped_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ped_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output ped_pkg::out_item_t res_item_o
);

  ped_pkg::dec_state_t state_q, state_d;

  logic [ped_pkg::CharW-1:0]  c;
  logic                       last;
  logic                       is_digit;
  logic                       is_letter;
  logic                       is_hex;
  logic [3:0]                 hex_val;
  logic [ped_pkg::AccumW-1:0] accum_new;
  logic [ped_pkg::DigitW-1:0] left_new;
  logic                       dv_en;
  logic                       dv_unit;
  logic [ped_pkg::CharW-1:0]  dv_val;
  logic                       er_en;
  logic [ped_pkg::StatusW-1:0] er_code;
  logic                       ok_en;
  logic [ped_pkg::CharW-1:0]  ok_val;
  ped_pkg::dec_state_t        st;

  assign c    = item_i.in_char;
  assign last = item_i.end_of_string;

  // Classify the character as a hex digit
  always_comb begin
    is_digit  = (c >= ped_pkg::CHR_ZERO) && (c <= ped_pkg::CHR_NINE);
    is_letter = ((c >= ped_pkg::CHR_LOW_A) && (c <= ped_pkg::CHR_LOW_F)) ||
                ((c >= ped_pkg::CHR_UP_A) && (c <= ped_pkg::CHR_UP_F));
    is_hex    = is_digit || is_letter;
    hex_val   = is_digit ? c[3:0] : 4'(c[3:0] + 4'd9);
  end

  // Step the escape parser for one request
  always_comb begin
    st        = state_q;
    dv_en     = 1'b0;
    dv_unit   = 1'b0;
    dv_val    = '0;
    er_en     = 1'b0;
    er_code   = ped_pkg::STAT_OK;
    ok_en     = 1'b0;
    ok_val    = '0;
    accum_new = {state_q.hex_accum[ped_pkg::AccumW-5:0], hex_val};
    left_new  = ped_pkg::DigitW'(state_q.digits_left - 3'd1);

    if (state_q.error_latched) begin
      if (last) st = ped_pkg::STATE_RESET;
    end else begin
      unique case (state_q.escape_phase)
        ped_pkg::PH_IDLE: begin
          if (c == ped_pkg::CHR_PERCENT) begin
            st.escape_phase = ped_pkg::PH_PCT;
            if (last) begin
              er_en   = 1'b1;
              er_code = ped_pkg::STAT_TRUNCATED;
            end
          end else begin
            dv_en  = 1'b1;
            dv_val = c;
          end
        end
        ped_pkg::PH_PCT: begin
          st.hex_accum = '0;
          if ((c == ped_pkg::CHR_LOW_U) || (c == ped_pkg::CHR_UP_U)) begin
            st.escape_phase = ped_pkg::PH_UNIT;
            st.digits_left  = ped_pkg::UNIT_DIGITS;
          end else begin
            st.digits_left = ped_pkg::BYTE_DIGITS;
            if (is_hex) begin
              st.escape_phase = ped_pkg::PH_BYTE;
              st.hex_accum    = ped_pkg::AccumW'(hex_val);
            end else begin
              st.escape_phase = ped_pkg::PH_BAD;
            end
          end
          if (last) begin
            er_en   = 1'b1;
            er_code = ped_pkg::STAT_TRUNCATED;
          end
        end
        ped_pkg::PH_BYTE, ped_pkg::PH_UNIT, ped_pkg::PH_BAD: begin
          if (is_hex) st.hex_accum = accum_new;
          else        st.escape_phase = ped_pkg::PH_BAD;
          st.digits_left = left_new;
          if (left_new == '0) begin
            if (st.escape_phase == ped_pkg::PH_BAD) begin
              er_en   = 1'b1;
              er_code = ped_pkg::STAT_ILLEGAL;
            end else begin
              dv_en   = 1'b1;
              dv_unit = (st.escape_phase == ped_pkg::PH_UNIT);
              dv_val  = ped_pkg::CharW'(st.hex_accum);
            end
          end else if (last) begin
            er_en   = 1'b1;
            er_code = ped_pkg::STAT_TRUNCATED;
          end
        end
        default: st = ped_pkg::STATE_RESET;
      endcase

      // Deliver a finished character, pairing surrogates from unit escapes
      if (dv_en) begin
        st.escape_phase = ped_pkg::PH_IDLE;
        st.digits_left  = '0;
        st.hex_accum    = '0;
        if (dv_unit && (dv_val[15:11] == ped_pkg::SURR_TAG)) begin
          if (!dv_val[10]) begin
            if (state_q.high_pending || last) begin
              er_en   = 1'b1;
              er_code = ped_pkg::STAT_UNPAIRED;
            end else begin
              st.high_surrogate = dv_val[9:0];
              st.high_pending   = 1'b1;
            end
          end else if (!state_q.high_pending) begin
            er_en   = 1'b1;
            er_code = ped_pkg::STAT_UNPAIRED;
          end else begin
            st.high_pending = 1'b0;
            ok_en  = 1'b1;
            ok_val = ped_pkg::CharW'(ped_pkg::SUPP_BASE +
                     {1'b0, state_q.high_surrogate, dv_val[9:0]});
          end
        end else if (state_q.high_pending) begin
          er_en   = 1'b1;
          er_code = ped_pkg::STAT_UNPAIRED;
        end else begin
          ok_en  = 1'b1;
          ok_val = dv_val;
        end
      end

      // Drop all state on an error or at the end of the string
      if (er_en) begin
        st               = ped_pkg::STATE_RESET;
        st.error_latched = !last;
      end else if (ok_en && last) begin
        st = ped_pkg::STATE_RESET;
      end
    end
    state_d = st;
  end

  // Result of the current request
  always_comb begin
    res_valid_o = accept_i && (er_en || ok_en);
    res_item_o  = '{code_point: '0, final_res: 1'b1, status: er_code};
    if (!er_en) begin
      res_item_o.code_point = ok_val;
      res_item_o.final_res  = last;
      res_item_o.status     = ped_pkg::STAT_OK;
    end
  end

  // Advance the state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ped_pkg::STATE_RESET;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/ped_outbuf.sv =====
// Result register with one skid entry, so one more result can be taken while
// the receiver stalls. Depends on ped_pkg.
module ped_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ped_pkg::out_item_t push_item_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ped_pkg::out_item_t out_item_o
);

  logic               out_vld_q, out_vld_d;
  logic               skid_vld_q, skid_vld_d;
  ped_pkg::out_item_t out_q, out_d;
  ped_pkg::out_item_t skid_q, skid_d;
  logic               pop;

  assign pop         = out_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Move results between the skid entry and the output register
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || pop) begin
        out_d     = push_item_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = push_item_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  // Hold the valid flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// ===== sv/ped_checker.sv =====
// Port-level checker for the percent escape decoder, bound to the top level.
// Depends on ped_pkg.
module ped_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ped_pkg::out_item_t out_item_o
);

  // Stall only while a result waits in the output register
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // An error result always closes the string
  a_error_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != ped_pkg::STAT_OK)) |-> out_item_o.final_res)
    else $error("error result without final_res");

  // An error result carries no code point
  a_error_zero_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != ped_pkg::STAT_OK)) |->
    (out_item_o.code_point == '0))
    else $error("error result with nonzero code point");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind percent_escape_decoder_top ped_port_checker u_ped_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== verif/ped_checker.sv =====
// Checker for the percent escape decoder: watches the request and result channels,
// predicts each decoded result and compares it field by field.
// Depends on ped_pkg for the request, result and state types.
module ped_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  ped_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  ped_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 expected_left_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ped_pkg::*;

  dec_state_t dec_st;
  out_item_t  decoded_q[$];
  out_item_t  want;

  initial begin
    fail_count_o    = 0;
    expected_left_o = 0;
    dec_st          = STATE_RESET;
  end

  // Print one line per mismatch and count it
  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    $display("%0t ped_checker: %s got 0x%0h want 0x%0h", $realtime, what, got, exp_val);
    fail_count_o++;
  endtask

  // Hex digit value, or -1 for anything that is not a hex digit
  function automatic int nibble_of(logic [CharW-1:0] c);
    if (c >= CHR_ZERO && c <= CHR_NINE) return int'(c - CHR_ZERO);
    if (c >= CHR_LOW_A && c <= CHR_LOW_F) return int'(c - CHR_LOW_A) + 10;
    if (c >= CHR_UP_A && c <= CHR_UP_F) return int'(c - CHR_UP_A) + 10;
    return -1;
  endfunction

  // Queue an error result; drop the rest of the string unless this is its end
  function automatic void push_error(logic [StatusW-1:0] code, bit last);
    out_item_t r;
    dec_st = STATE_RESET;
    if (!last) dec_st.error_latched = 1'b1;
    r.code_point = '0;
    r.final_res  = 1'b1;
    r.status     = code;
    decoded_q.push_back(r);
  endfunction

  // Queue a decoded character
  function automatic void push_char(logic [CharW-1:0] v, bit last);
    out_item_t r;
    if (last) dec_st = STATE_RESET;
    r.code_point = v;
    r.final_res  = last;
    r.status     = STAT_OK;
    decoded_q.push_back(r);
  endfunction

  // Close an escape or a plain character, pairing surrogate units
  function automatic void close_value(logic [CharW-1:0] v, bit from_unit, bit last);
    dec_st.escape_phase = PH_IDLE;
    dec_st.digits_left  = '0;
    dec_st.hex_accum    = '0;
    if (from_unit && v[15:11] == SURR_TAG) begin
      if (!v[10]) begin
        // high half: hold it for its partner
        if (dec_st.high_pending) begin
          push_error(STAT_UNPAIRED, last);
          return;
        end
        dec_st.high_surrogate = v[9:0];
        dec_st.high_pending   = 1'b1;
        if (last) push_error(STAT_UNPAIRED, last);
        return;
      end
      if (!dec_st.high_pending) begin
        push_error(STAT_UNPAIRED, last);
        return;
      end
      dec_st.high_pending = 1'b0;
      push_char(SUPP_BASE + CharW'({dec_st.high_surrogate, v[9:0]}), last);
      return;
    end
    if (dec_st.high_pending) push_error(STAT_UNPAIRED, last);
    else push_char(v, last);
  endfunction

  // Advance the decoder by one accepted character
  function automatic void predict_char(in_item_t it);
    logic [CharW-1:0] c;
    bit               last;
    int               nib;
    c    = it.in_char;
    last = it.end_of_string;
    if (dec_st.error_latched) begin
      if (last) dec_st = STATE_RESET;
      return;
    end
    case (dec_st.escape_phase)
      PH_IDLE: begin
        if (c == CHR_PERCENT) begin
          dec_st.escape_phase = PH_PCT;
          if (last) push_error(STAT_TRUNCATED, last);
        end else begin
          close_value(c, 1'b0, last);
        end
      end
      PH_PCT: begin
        dec_st.hex_accum = '0;
        if (c == CHR_LOW_U || c == CHR_UP_U) begin
          dec_st.escape_phase = PH_UNIT;
          dec_st.digits_left  = UNIT_DIGITS;
        end else begin
          nib = nibble_of(c);
          dec_st.digits_left = BYTE_DIGITS;
          if (nib >= 0) begin
            dec_st.escape_phase = PH_BYTE;
            dec_st.hex_accum    = AccumW'(nib);
          end else begin
            dec_st.escape_phase = PH_BAD;
          end
        end
        if (last) push_error(STAT_TRUNCATED, last);
      end
      PH_BYTE, PH_UNIT, PH_BAD: begin
        nib = nibble_of(c);
        if (nib >= 0) dec_st.hex_accum = {dec_st.hex_accum[AccumW-5:0], nib[3:0]};
        else dec_st.escape_phase = PH_BAD;
        dec_st.digits_left = dec_st.digits_left - 1'b1;
        if (dec_st.digits_left == '0) begin
          if (dec_st.escape_phase == PH_BAD) push_error(STAT_ILLEGAL, last);
          else close_value(CharW'(dec_st.hex_accum), dec_st.escape_phase == PH_UNIT, last);
        end else if (last) begin
          push_error(STAT_TRUNCATED, last);
        end
      end
      default: dec_st = STATE_RESET;
    endcase
  endfunction

  // Compare taken results first, then predict from the taken request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dec_st = STATE_RESET;
      decoded_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing expected, code_point",
                          out_item_i.code_point, 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_item_i.code_point !== want.code_point)
            report_mismatch("code_point", out_item_i.code_point, want.code_point);
          if (out_item_i.final_res !== want.final_res)
            report_mismatch("final_res", out_item_i.final_res, want.final_res);
          if (out_item_i.status !== want.status)
            report_mismatch("status", out_item_i.status, want.status);
        end
      end
      if (in_valid_i && !in_stall_i) predict_char(in_item_i);
    end
    expected_left_o = decoded_q.size();
  end

endmodule

// ===== verif/tb_percent_escape_decoder_top.sv =====
// Testbench top for the percent escape decoder: clock, reset, request
// stimulus, receiver stalls, watchdog and verdict.
// Depends on ped_pkg, percent_escape_decoder_top and ped_checker.
module tb_percent_escape_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ped_pkg::*;

  localparam int ItemTarget    = 850;
  localparam int QuietLimit    = 3000;
  localparam int HoldOffCycles = 64;
  localparam int BrokenPct     = 20;

  // Characters next to the hex digit ranges, and '+'
  localparam logic [CharW-1:0] CHR_SLASH = 21'h2F;
  localparam logic [CharW-1:0] CHR_COLON = 21'h3A;
  localparam logic [CharW-1:0] CHR_AT    = 21'h40;
  localparam logic [CharW-1:0] CHR_UP_G  = 21'h47;
  localparam logic [CharW-1:0] CHR_GRAVE = 21'h60;
  localparam logic [CharW-1:0] CHR_LOW_G = 21'h67;
  localparam logic [CharW-1:0] CHR_PLUS  = 21'h2B;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_req    = '0;
  logic      out_stall = 1'b0;
  logic      hold_off  = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_res;
  int        fail_count;
  int        expected_left;
  int        idle_pct  = 0;
  int        stall_pct = 0;
  int        quiet_cycles = 0;
  int        items_sent = 0;
  int        live_len;
  logic [CharW-1:0] str_q[$];

  percent_escape_decoder_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_res)
  );

  ped_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_item_i       (in_req),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_item_i      (out_res),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, or hold off completely
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb_percent_escape_decoder_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hex digit character in random case
  function automatic logic [CharW-1:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CHR_ZERO + n;
    if ($urandom_range(1)) return CHR_UP_A + (n - 4'd10);
    return CHR_LOW_A + (n - 4'd10);
  endfunction

  // Character that is neither a hex digit nor a unit marker
  function automatic logic [CharW-1:0] non_hex();
    case ($urandom_range(6))
      0: return CHR_SLASH;
      1: return CHR_COLON;
      2: return CHR_AT;
      3: return CHR_UP_G;
      4: return CHR_GRAVE;
      5: return CHR_LOW_G;
      default: return CharW'($urandom_range(21'h1FFFFF, 21'h80));
    endcase
  endfunction

  function automatic void add_byte(logic [7:0] v);
    str_q.push_back(CHR_PERCENT);
    str_q.push_back(hex_char(v[7:4]));
    str_q.push_back(hex_char(v[3:0]));
  endfunction

  function automatic void add_unit(logic [15:0] v);
    str_q.push_back(CHR_PERCENT);
    str_q.push_back($urandom_range(1) ? CHR_UP_U : CHR_LOW_U);
    for (int i = 3; i >= 0; i--) str_q.push_back(hex_char(v[4*i +: 4]));
  endfunction

  // Plain character: mostly printable, sometimes any 21-bit code
  function automatic void add_plain();
    logic [CharW-1:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: c = CharW'($urandom_range(8'h7E, 8'h20));
      5, 6:          c = CharW'($urandom_range(21'h1FFFFF, 0));
      7:             c = CHR_PLUS;
      8:             c = CharW'($urandom_range(16'hDFFF, 16'hD800));
      default:       c = CharW'($urandom_range(16'hFFFF, 0));
    endcase
    if (c == CHR_PERCENT) c = CHR_UP_A;
    str_q.push_back(c);
  endfunction

  // Well-formed piece: plain character, byte escape, unit or surrogate pair
  function automatic void add_good();
    logic [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: add_plain();
      4, 5:       add_byte(8'($urandom_range(255)));
      6, 7: begin
        v = 16'($urandom_range(16'hFFFF));
        if (v[15:11] == SURR_TAG) v[15] = 1'b0;
        add_unit(v);
      end
      default: begin
        add_unit({6'b110110, 10'($urandom_range(10'h3FF))});
        add_unit({6'b110111, 10'($urandom_range(10'h3FF))});
      end
    endcase
  endfunction

  // Broken piece; returns 1 when the string must end right here
  function automatic bit add_broken();
    int n_dig;
    int bad_pos;
    bit is_unit;
    case ($urandom_range(5))
      0: add_unit({6'b110110, 10'($urandom_range(10'h3FF))});
      1: add_unit({6'b110111, 10'($urandom_range(10'h3FF))});
      2: begin
        // escape with one non-hex digit somewhere in it
        is_unit = $urandom_range(1);
        n_dig   = is_unit ? 4 : 2;
        bad_pos = $urandom_range(n_dig - 1);
        str_q.push_back(CHR_PERCENT);
        if (is_unit) str_q.push_back($urandom_range(1) ? CHR_UP_U : CHR_LOW_U);
        for (int i = 0; i < n_dig; i++)
          str_q.push_back(i == bad_pos ? non_hex() : hex_char(4'($urandom_range(15))));
      end
      3: begin
        // escape cut off by the end of the string
        is_unit = $urandom_range(1);
        n_dig   = is_unit ? $urandom_range(3) : $urandom_range(1);
        str_q.push_back(CHR_PERCENT);
        if (is_unit) str_q.push_back($urandom_range(1) ? CHR_UP_U : CHR_LOW_U);
        for (int i = 0; i < n_dig; i++)
          str_q.push_back($urandom_range(2) == 0 ? non_hex() : hex_char(4'($urandom_range(15))));
        return 1'b1;
      end
      4: begin
        add_unit({6'b110110, 10'($urandom_range(10'h3FF))});
        add_byte(8'($urandom_range(255)));
      end
      default: begin
        add_unit({6'b110110, 10'($urandom_range(10'h3FF))});
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void build_string(bit broken);
    int n_pieces;
    int bad_at;
    n_pieces = $urandom_range(5, 1);
    bad_at   = $urandom_range(n_pieces - 1);
    str_q.delete();
    live_len = 0;
    for (int i = 0; i < n_pieces; i++) begin
      if (broken && i == bad_at) begin
        // requests after the error are dropped, so leave them out of the count
        if (add_broken()) begin
          live_len = str_q.size();
          break;
        end
        live_len = str_q.size();
      end else begin
        add_good();
      end
    end
    if (live_len == 0) live_len = str_q.size();
  endfunction

  // Offer one request, with random idle cycles ahead of it
  task automatic send_char(logic [CharW-1:0] c, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{in_char: c, end_of_string: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_char(str_q[i], i == str_q.size() - 1);
    items_sent += live_len;
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 46, 0, 17};
    stall_tab = '{0, 0, 46, 17};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: wide literal, '+', byte escape in mixed case
    str_q = '{CHR_PLUS, 21'h1FFFFF, CHR_PERCENT, CHR_LOW_F, CHR_UP_F};
    live_len = str_q.size();
    send_string();
    // surrogate pair from %u and %U
    str_q.delete();
    add_unit(16'hD83D);
    str_q[1] = CHR_LOW_U;
    add_unit(16'hDE00);
    str_q[7] = CHR_UP_U;
    live_len = str_q.size();
    send_string();
    // non-hex first digit, then a dropped tail
    str_q = '{CHR_PERCENT, CHR_LOW_G, CHR_NINE, 21'h0};
    live_len = str_q.size();
    send_string();
    // lone percent at the end
    str_q = '{CHR_PERCENT};
    live_len = 1;
    send_string();
    // low surrogate with no high before it
    str_q.delete();
    add_unit(16'hDC00);
    live_len = str_q.size();
    send_string();

    // Random strings over the idling phases
    items_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct <= stall_tab[ph];
      if (ph == 0) begin
        // hold off the receiver so the result buffer fills and stalls requests
        fork
          begin
            hold_off <= 1'b1;
            repeat (HoldOffCycles) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      while (items_sent < ItemTarget * (ph + 1) / 4) begin
        build_string($urandom_range(99) < BrokenPct);
        send_string();
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block idle before the verdict
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_percent_escape_decoder_top: done, clean");
    end else begin
      $display("tb_percent_escape_decoder_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== percent_escape_decoder_top.f =====
sv/ped_pkg.sv
sv/ped_core.sv
sv/ped_outbuf.sv
sv/percent_escape_decoder_top.sv
sv/ped_checker.sv
verif/ped_checker.sv
verif/tb_percent_escape_decoder_top.sv
